// ===== rtl/wspm_pkg.sv =====
package wspm_pkg;

    localparam int WHEEL_COUNT = 4;
    localparam int WHEEL_W     = 2;
    localparam int SPEED_W     = 16;
    localparam int FACTOR_W    = 16;
    localparam int DEV_W       = 20;
    localparam int PERSIST_W   = 6;
    localparam int Q_SHIFT     = 14;
    localparam int PRODUCT_W   = SPEED_W + FACTOR_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [FACTOR_W-1:0]  UNITY_Q14   = 16'h4000;
    localparam logic [PERSIST_W-1:0] PERSIST_MAX = 6'd63;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAL_FACTORS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_CYCLES = 3'd4;

    // reset values
    localparam logic [CFG_DATA_W-1:0] CAL_FACTORS_RST    = 64'h4000_4000_4000_4000;
    localparam logic [SPEED_W-1:0]    DRIFT_LIMIT_RST    = 16'd1638;
    localparam logic [SPEED_W-1:0]    DIFF_LIMIT_RST     = 16'd2560;
    localparam logic [DEV_W-1:0]      ACCEL_LIMIT_RST    = 20'd1920;
    localparam logic [PERSIST_W-1:0]  CONFIRM_CYCLES_RST = 6'd6;

    // fault codes
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_CAL   = 2'd1;
    localparam logic [1:0] FAULT_DEV   = 2'd2;
    localparam logic [1:0] FAULT_ACCEL = 2'd3;

    typedef logic [WHEEL_COUNT-1:0][SPEED_W-1:0] speed_vec_t;

    typedef struct packed {
        logic [SPEED_W-1:0] raw_speed_fl;
        logic [SPEED_W-1:0] raw_speed_fr;
        logic [SPEED_W-1:0] raw_speed_rl;
        logic [SPEED_W-1:0] raw_speed_rr;
    } sample_t;

    typedef struct packed {
        logic [WHEEL_W-1:0] wheel_index;
        logic [1:0]         fault_code;
        logic               fault_active;
        logic               fault_confirmed;
        logic [DEV_W-1:0]   deviation;
        logic [SPEED_W-1:0] calibrated_speed;
        logic               last_of_set;
    } result_t;

    typedef struct packed {
        logic [FACTOR_W-1:0]  drift_limit;
        logic [SPEED_W-1:0]   diff_limit;
        logic [DEV_W-1:0]     accel_limit;
        logic [PERSIST_W-1:0] confirm_cycles;
    } limits_t;

    typedef struct packed {
        logic [1:0]         fault_code;
        logic               fault_confirmed;
        logic [DEV_W-1:0]   deviation;
        logic [SPEED_W-1:0] calibrated_speed;
    } lane_result_t;

endpackage

// ===== rtl/wspm_cal_lane.sv =====
module wspm_cal_lane
    import wspm_pkg::*;
(
    input  logic                clk,
    input  logic                load,
    input  logic [SPEED_W-1:0]  raw_speed,
    input  logic [FACTOR_W-1:0] factor,
    output logic [SPEED_W-1:0]  speed_reg
);

    logic [PRODUCT_W-1:0] product;
    logic [SPEED_W-1:0]   speed_next;

    assign product = PRODUCT_W'(raw_speed) * PRODUCT_W'(factor);

    // truncate the Q18.14 product, saturate at full scale
    always_comb
    begin
        if (|product[PRODUCT_W-1:SPEED_W+Q_SHIFT])
            speed_next = '1;
        else
            speed_next = product[SPEED_W+Q_SHIFT-1:Q_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (load)
            speed_reg <= speed_next;
    end

endmodule

// ===== rtl/wspm_median.sv =====
module wspm_median
    import wspm_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  speed_vec_t         speeds,
    output speed_vec_t         speeds_reg,
    output logic [SPEED_W-1:0] median_reg
);

    logic [SPEED_W-1:0] lo01, hi01, lo23, hi23, mid_a, mid_b, median_next;
    logic [SPEED_W:0]   mid_sum;

    // middle two of four = larger pair-minimum and smaller pair-maximum
    always_comb
    begin
        lo01 = (speeds[0] < speeds[1]) ? speeds[0] : speeds[1];
        hi01 = (speeds[0] < speeds[1]) ? speeds[1] : speeds[0];
        lo23 = (speeds[2] < speeds[3]) ? speeds[2] : speeds[3];
        hi23 = (speeds[2] < speeds[3]) ? speeds[3] : speeds[2];
        mid_a = (lo01 > lo23) ? lo01 : lo23;
        mid_b = (hi01 < hi23) ? hi01 : hi23;
        mid_sum = (SPEED_W+1)'(mid_a) + (SPEED_W+1)'(mid_b);
        median_next = mid_sum[SPEED_W:1];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            speeds_reg <= speeds;
            median_reg <= median_next;
        end
    end

endmodule

// ===== rtl/wspm_check_lane.sv =====
module wspm_check_lane
    import wspm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [SPEED_W-1:0]  speed,
    input  logic [SPEED_W-1:0]  median,
    input  logic [FACTOR_W-1:0] factor,
    input  limits_t             limits,
    output lane_result_t        result_reg
);

    logic [SPEED_W-1:0]   prev_speed_reg;
    logic [PERSIST_W-1:0] persist_reg, persist_next;
    logic                 confirmed_reg, confirmed_next;

    logic [FACTOR_W-1:0] drift;
    logic [SPEED_W-1:0]  dmed, delta;
    logic [DEV_W-1:0]    accel;
    lane_result_t        result_next;

    always_comb
    begin
        drift = (factor >= UNITY_Q14) ? factor - UNITY_Q14 : UNITY_Q14 - factor;
        dmed  = (speed >= median) ? speed - median : median - speed;
        delta = (speed >= prev_speed_reg) ? speed - prev_speed_reg : prev_speed_reg - speed;
        accel = DEV_W'({delta, 3'b000}) + DEV_W'({delta, 1'b0});

        persist_next   = persist_reg;
        confirmed_next = confirmed_reg;
        result_next.fault_code = FAULT_NONE;
        result_next.deviation  = '0;

        if (drift > limits.drift_limit)
        begin
            // drift rewrites the flag from the persistence count, may clear it
            if (persist_reg != PERSIST_MAX)
                persist_next = persist_reg + PERSIST_W'(1);
            confirmed_next = (persist_next > limits.confirm_cycles);
            result_next.fault_code = FAULT_CAL;
            result_next.deviation  = DEV_W'(drift);
        end
        else
        begin
            persist_next = '0;
            if (dmed > limits.diff_limit)
            begin
                confirmed_next = 1'b1;
                result_next.fault_code = FAULT_DEV;
                result_next.deviation  = DEV_W'(dmed);
            end
            else if (accel > limits.accel_limit)
            begin
                confirmed_next = 1'b1;
                result_next.fault_code = FAULT_ACCEL;
                result_next.deviation  = accel;
            end
        end

        result_next.fault_confirmed  = confirmed_next;
        result_next.calibrated_speed = speed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_speed_reg <= '0;
            persist_reg    <= '0;
            confirmed_reg  <= 1'b0;
        end
        else if (load)
        begin
            prev_speed_reg <= speed;
            persist_reg    <= persist_next;
            confirmed_reg  <= confirmed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

endmodule

// ===== rtl/wheel_speed_plausibility_monitor_core.sv =====
// Wheel speed plausibility monitor. Each sample beat carries four raw wheel
// speeds (1/128 km/h); the block answers with four result beats, one per
// wheel in the order FL, FR, RL, RR, the last one flagged by last_of_set.
// Four lanes calibrate the speeds (16x16 multiply by the Q2.14 factor,
// saturating), a merge stage forms the median of the middle two, and four
// check lanes apply drift, median-deviation and acceleration checks in that
// priority while updating each wheel's history. A sample passes the
// calibration, median and result-set registers before its first result
// beat is offered. Throughput is set by the single result port, which
// carries one wheel per cycle while result_ready is high; up to two
// further sample sets wait in the calibration and median stages while a
// set drains, and once both are full sample_ready stays low until the
// cycle in which the last beat of the draining set is taken.
// Configuration writes take effect at once and are meant for idle periods.
module wheel_speed_plausibility_monitor_core
    import wspm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  sample_t               sample,

    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ---------------- configuration registers ----------------
    logic [CFG_DATA_W-1:0] cal_factors_reg;
    limits_t               limits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_factors_reg           <= CAL_FACTORS_RST;
            limits_reg.drift_limit    <= DRIFT_LIMIT_RST;
            limits_reg.diff_limit     <= DIFF_LIMIT_RST;
            limits_reg.accel_limit    <= ACCEL_LIMIT_RST;
            limits_reg.confirm_cycles <= CONFIRM_CYCLES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAL_FACTORS:    cal_factors_reg           <= cfg_data;
                REG_DRIFT_LIMIT:    limits_reg.drift_limit    <= cfg_data[FACTOR_W-1:0];
                REG_DIFF_LIMIT:     limits_reg.diff_limit     <= cfg_data[SPEED_W-1:0];
                REG_ACCEL_LIMIT:    limits_reg.accel_limit    <= cfg_data[DEV_W-1:0];
                REG_CONFIRM_CYCLES: limits_reg.confirm_cycles <= cfg_data[PERSIST_W-1:0];
                default:            ; // unmapped index, write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // stage 1: calibrated speeds, stage 2: median, stage 3: result set
    logic               stage1_valid_reg, stage1_valid_next;
    logic               stage2_valid_reg, stage2_valid_next;
    logic               set_valid_reg, set_valid_next;
    logic [WHEEL_W-1:0] beat_cnt_reg, beat_cnt_next;
    logic               beat_done, set_done;
    logic               set_free, stage2_free, stage1_free;
    logic               load1, load2, load3;

    assign beat_done   = result_valid && result_ready;
    assign set_done    = beat_done && (beat_cnt_reg == WHEEL_W'(WHEEL_COUNT - 1));
    assign set_free    = !set_valid_reg || set_done;
    assign load3       = stage2_valid_reg && set_free;
    assign stage2_free = !stage2_valid_reg || load3;
    assign load2       = stage1_valid_reg && stage2_free;
    assign stage1_free = !stage1_valid_reg || load2;
    assign sample_ready = stage1_free;
    assign load1       = sample_valid && sample_ready;

    always_comb
    begin
        stage1_valid_next = load1 || (stage1_valid_reg && !load2);
        stage2_valid_next = load2 || (stage2_valid_reg && !load3);
        set_valid_next    = load3 || (set_valid_reg && !set_done);
        // wraps to wheel 0 after the last wheel
        beat_cnt_next     = beat_done ? beat_cnt_reg + WHEEL_W'(1) : beat_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_valid_reg <= 1'b0;
            stage2_valid_reg <= 1'b0;
            set_valid_reg    <= 1'b0;
            beat_cnt_reg     <= '0;
        end
        else
        begin
            stage1_valid_reg <= stage1_valid_next;
            stage2_valid_reg <= stage2_valid_next;
            set_valid_reg    <= set_valid_next;
            beat_cnt_reg     <= beat_cnt_next;
        end
    end

    // ---------------- datapath ----------------
    speed_vec_t         raw_vec;
    speed_vec_t         cal_speeds;
    speed_vec_t         med_speeds;
    logic [SPEED_W-1:0] median;
    lane_result_t       lane_results [WHEEL_COUNT];

    assign raw_vec[0] = sample.raw_speed_fl;
    assign raw_vec[1] = sample.raw_speed_fr;
    assign raw_vec[2] = sample.raw_speed_rl;
    assign raw_vec[3] = sample.raw_speed_rr;

    for (genvar w = 0; w < WHEEL_COUNT; w++)
    begin : g_cal
        wspm_cal_lane u_cal (
            .clk       (clk),
            .load      (load1),
            .raw_speed (raw_vec[w]),
            .factor    (cal_factors_reg[w*FACTOR_W +: FACTOR_W]),
            .speed_reg (cal_speeds[w])
        );
    end

    wspm_median u_median (
        .clk        (clk),
        .load       (load2),
        .speeds     (cal_speeds),
        .speeds_reg (med_speeds),
        .median_reg (median)
    );

    // the user must keep factors stable while samples are in flight (the block does
    // not enforce it), so the live register is used in the check stage as well
    for (genvar w = 0; w < WHEEL_COUNT; w++)
    begin : g_check
        wspm_check_lane u_check (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (load3),
            .speed      (med_speeds[w]),
            .median     (median),
            .factor     (cal_factors_reg[w*FACTOR_W +: FACTOR_W]),
            .limits     (limits_reg),
            .result_reg (lane_results[w])
        );
    end

    // ---------------- result serializer ----------------
    lane_result_t cur;

    assign cur          = lane_results[beat_cnt_reg];
    assign result_valid = set_valid_reg;

    always_comb
    begin
        result.wheel_index      = beat_cnt_reg;
        result.fault_code       = cur.fault_code;
        result.fault_active     = (cur.fault_code != FAULT_NONE);
        result.fault_confirmed  = cur.fault_confirmed;
        result.deviation        = cur.deviation;
        result.calibrated_speed = cur.calibrated_speed;
        result.last_of_set      = (beat_cnt_reg == WHEEL_W'(WHEEL_COUNT - 1));
    end

`ifndef NO_ASSERTIONS
    // a partly drained set must still be held
    a_cnt_needs_set: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_cnt_reg != '0) |-> set_valid_reg)
        else $error("beat counter advanced without a result set");

    // input stalls only when the calibration stage is occupied
    a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> stage1_valid_reg)
        else $error("sample_ready low with empty calibration stage");

    // the last beat of a set returns the serializer to wheel 0
    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && result.last_of_set) |=> (beat_cnt_reg == '0))
        else $error("serializer did not wrap after last beat");
`endif

endmodule
